// ----- rtl/mu8d_pkg.sv -----
package mu8d_pkg;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CONT_LEAD = 2'd1;
  localparam logic [1:0] ST_BAD_LEAD  = 2'd2;
  localparam logic [1:0] ST_TRUNC     = 2'd3;

  localparam int unsigned CP_W = 21;

  // byte classes and masks
  localparam logic [7:0]      ASCII_TOP  = 8'h80;
  localparam logic [7:0]      LEAD2_BASE = 8'hC0;
  localparam logic [7:0]      LEAD3_BASE = 8'hE0;
  localparam logic [7:0]      LEAD4_BASE = 8'hF0;
  localparam logic [7:0]      SURR_LEAD  = 8'hED;
  localparam logic [7:0]      SURR_MIN   = 8'hA0;
  localparam logic [7:0]      MASK_LEAD2 = 8'h1F;
  localparam logic [7:0]      MASK_LEAD3 = 8'h0F;
  localparam logic [CP_W-1:0] SUPP_BASE  = 21'h10000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_string;
  } in_word_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic [1:0]      status;
    logic            string_end;
  } out_word_t;

  typedef struct packed {
    logic [2:0]      bytes_remaining;
    logic [CP_W-1:0] partial_value;
    logic            pair_mode;
    logic            lead_was_ed;
    logic            discarding;
  } dec_state_t;

endpackage

// ----- rtl/mu8d_step.sv -----
module mu8d_step
  import mu8d_pkg::*;
(
  input  dec_state_t cur,
  input  in_word_t   word,
  output dec_state_t nxt,
  output logic       emit,
  output out_word_t  res
);

  logic [7:0]      b;
  logic            last;
  logic [CP_W-1:0] sh6;
  logic [CP_W-1:0] sh4;
  logic [2:0]      rem_dec;
  logic            mid_seq;

  assign b       = word.data_byte;
  assign last    = word.last_of_string;
  assign sh6     = {cur.partial_value[CP_W-7:0], b[5:0]};
  assign sh4     = {cur.partial_value[CP_W-5:0], b[3:0]};
  assign rem_dec = cur.bytes_remaining - 3'd1;

  always_comb begin
    nxt     = cur;
    emit    = 1'b0;
    res     = '0;
    mid_seq = 1'b0; // sequence still open after this byte

    priority if (cur.discarding) begin
      if (last) begin
        nxt.discarding = 1'b0;
      end
    end else if (cur.bytes_remaining == 3'd0) begin
      priority if (b < ASCII_TOP) begin
        emit           = 1'b1;
        res.code_point = {{(CP_W-8){1'b0}}, b};
        res.status     = ST_OK;
        res.string_end = last;
      end else if (b < LEAD2_BASE || b >= LEAD4_BASE) begin
        nxt                 = '0;
        nxt.discarding      = !last;
        emit                = 1'b1;
        res.status          = (b < LEAD2_BASE) ? ST_CONT_LEAD : ST_BAD_LEAD;
        res.string_end      = last;
      end else if (b < LEAD3_BASE) begin
        nxt.partial_value   = {{(CP_W-8){1'b0}}, b & MASK_LEAD2};
        nxt.bytes_remaining = 3'd1;
        nxt.pair_mode       = 1'b0;
        mid_seq             = 1'b1;
      end else begin
        nxt.partial_value   = {{(CP_W-8){1'b0}}, b & MASK_LEAD3};
        nxt.bytes_remaining = 3'd2;
        nxt.lead_was_ed     = (b == SURR_LEAD);
        nxt.pair_mode       = 1'b0;
        mid_seq             = 1'b1;
      end
    end else if (cur.lead_was_ed) begin
      nxt.lead_was_ed = 1'b0;
      mid_seq         = 1'b1;
      if (b >= SURR_MIN) begin
        // surrogate pair: keep the low nibble of the second byte
        nxt.pair_mode       = 1'b1;
        nxt.partial_value   = {{(CP_W-8){1'b0}}, b & MASK_LEAD3};
        nxt.bytes_remaining = 3'd4;
      end else begin
        nxt.partial_value   = sh6;
        nxt.bytes_remaining = 3'd1;
      end
    end else if (cur.pair_mode) begin
      unique case (cur.bytes_remaining)
        3'd4, 3'd1: nxt.partial_value = sh6;
        3'd2:       nxt.partial_value = sh4;
        default:    nxt.partial_value = cur.partial_value; // second ED ignored
      endcase
      nxt.bytes_remaining = rem_dec;
      if (rem_dec == 3'd0) begin
        emit           = 1'b1;
        res.code_point = SUPP_BASE + nxt.partial_value;
        res.status     = ST_OK;
        res.string_end = last;
        nxt            = '0;
      end else begin
        mid_seq = 1'b1;
      end
    end else begin
      nxt.partial_value   = sh6;
      nxt.bytes_remaining = rem_dec;
      if (rem_dec == 3'd0) begin
        emit           = 1'b1;
        res.code_point = sh6;
        res.status     = ST_OK;
        res.string_end = last;
        nxt            = '0;
      end else begin
        mid_seq = 1'b1;
      end
    end

    // string ended inside a sequence
    if (mid_seq && last) begin
      nxt            = '0;
      emit           = 1'b1;
      res.code_point = '0;
      res.status     = ST_TRUNC;
      res.string_end = 1'b1;
    end
  end

endmodule

// ----- rtl/modified_utf8_decoder_top.sv -----
// channel | ports                        | word
// --------+------------------------------+---------------------------------------
// input   | in_valid, in_ready, in_word  | data_byte, last_of_string
// result  | out_valid, out_ready, out_word | code_point, status, string_end
//
// one byte a cycle sustained while the result side keeps up; a result
// appears once its byte has been taken into the input register and the
// decode step has loaded the result register, which waits for a free slot
// the decode state updates as a byte leaves the input register
// rst_n is synchronous and active low; it clears the valid flags and state
// a held result stalls the input register only if that byte makes a result;
// bytes that make none keep flowing past a waiting result
module modified_utf8_decoder_top
  import mu8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  // input register
  logic       in_vld_r;
  in_word_t   in_buf_r;

  // decode state
  dec_state_t st_r;
  dec_state_t st_nxt;

  // result register
  logic       out_vld_r;
  out_word_t  out_buf_r;

  logic       step_emit;
  out_word_t  step_res;
  logic       out_free;
  logic       advance;

  mu8d_step u_step (
    .cur  (st_r),
    .word (in_buf_r),
    .nxt  (st_nxt),
    .emit (step_emit),
    .res  (step_res)
  );

  // result slot is free if empty or being drained this cycle
  assign out_free = !out_vld_r || out_ready;
  // the buffered byte moves on unless its result has nowhere to go
  assign advance  = in_vld_r && (!step_emit || out_free);
  assign in_ready = !in_vld_r || advance;

  assign out_valid = out_vld_r;
  assign out_word  = out_buf_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      if (advance && step_emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_buf_r <= in_word;
    end
    if (advance && step_emit) begin
      out_buf_r <= step_res;
    end
  end

endmodule

// ----- verif/tb_modified_utf8_decoder_top.sv -----
module tb_modified_utf8_decoder_top;
  import mu8d_pkg::*;

  // run length guards
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TARGET_BYTES = 1300;
  // allow a margin for bytes that make no result but may still be in
  // flight
  localparam int DRAIN_CYCLES = 12;

  // idling styles: none, full random wait, occasional wait
  localparam int IDLE_NONE = 0;
  localparam int IDLE_FULL = 1;
  localparam int IDLE_RARE = 2;

  // ---------------------------------------------------------------------------
  // decoded-character tracker: mirrors the decoder state byte by byte and
  // keeps the characters (or error words) still owed by the block
  // ---------------------------------------------------------------------------
  class char_tracker;
    logic [2:0]      left_cnt = '0;   // continuation bytes still owed
    logic [CP_W-1:0] acc      = '0;   // value gathered so far
    bit              in_pair  = 1'b0; // inside a surrogate pair
    bit              after_ed = 1'b0; // lead was 0xED, second byte pending
    bit              skipping = 1'b0; // dropping bytes after a bad lead
    out_word_t       due_chars[$];
    int              mismatches = 0;

    function void clear_seq();
      left_cnt = '0;
      acc      = '0;
      in_pair  = 1'b0;
      after_ed = 1'b0;
    endfunction

    function void owe(logic [CP_W-1:0] cp, logic [1:0] st, logic fin);
      out_word_t w;
      w.code_point = cp;
      w.status     = st;
      w.string_end = fin;
      due_chars.push_back(w);
    endfunction

    // returns 1 when the byte took part in decoding, 0 when it was dropped
    function bit take_byte(in_word_t w);
      logic [7:0] b;
      logic       fin;
      logic [CP_W-1:0] cp;
      b   = w.data_byte;
      fin = w.last_of_string;
      if (skipping) begin
        if (fin) skipping = 1'b0;
        return 1'b0;
      end
      if (left_cnt == 0) begin
        if (b < ASCII_TOP) begin
          owe(CP_W'(b), ST_OK, fin);
          return 1'b1;
        end
        if (b < LEAD2_BASE || b >= LEAD4_BASE) begin
          clear_seq();
          skipping = !fin;
          owe('0, (b < LEAD2_BASE) ? ST_CONT_LEAD : ST_BAD_LEAD, fin);
          return 1'b1;
        end
        if (b < LEAD3_BASE) begin
          acc      = CP_W'(b & MASK_LEAD2);
          left_cnt = 3'd1;
        end else begin
          acc      = CP_W'(b & MASK_LEAD3);
          left_cnt = 3'd2;
          after_ed = (b == SURR_LEAD);
        end
        in_pair = 1'b0;
      end else if (after_ed) begin
        after_ed = 1'b0;
        if (b >= SURR_MIN) begin
          in_pair  = 1'b1;
          acc      = CP_W'(b[3:0]);
          left_cnt = 3'd4;
        end else begin
          acc      = (acc << 6) | CP_W'(b[5:0]);
          left_cnt = 3'd1;
        end
      end else if (in_pair) begin
        // third byte and sixth byte carry six bits, fifth carries four,
        // the repeated 0xED in fourth place is simply swallowed
        if (left_cnt == 3'd4 || left_cnt == 3'd1)
          acc = (acc << 6) | CP_W'(b[5:0]);
        else if (left_cnt == 3'd2)
          acc = (acc << 4) | CP_W'(b[3:0]);
        left_cnt = left_cnt - 3'd1;
        if (left_cnt == 0) begin
          cp = SUPP_BASE + acc;
          clear_seq();
          owe(cp, ST_OK, fin);
          return 1'b1;
        end
      end else begin
        acc      = (acc << 6) | CP_W'(b[5:0]);
        left_cnt = left_cnt - 3'd1;
        if (left_cnt == 0) begin
          cp = acc;
          clear_seq();
          owe(cp, ST_OK, fin);
          return 1'b1;
        end
      end
      // string ran out part way through a sequence
      if (fin) begin
        clear_seq();
        owe('0, ST_TRUNC, 1'b1);
      end
      return 1'b1;
    endfunction

    function void check_char(out_word_t got);
      out_word_t want;
      if (due_chars.size() == 0) begin
        $error("result word with nothing owed: code_point %0h status %0d string_end %0d",
               got.code_point, got.status, got.string_end);
        mismatches++;
        return;
      end
      want = due_chars.pop_front();
      if (got.code_point !== want.code_point) begin
        $error("code_point expected %0h actual %0h", want.code_point, got.code_point);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.string_end !== want.string_end) begin
        $error("string_end expected %0d actual %0d", want.string_end, got.string_end);
        mismatches++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // signals and block under test
  // ---------------------------------------------------------------------------
  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  char_tracker chars;
  int          fed_bytes = 0;  // bytes accepted by the block
  int          cycle_cnt = 0;
  int          in_idle   = IDLE_NONE;
  int          out_idle  = IDLE_NONE;

  modified_utf8_decoder_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // clock, period of four units
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // every input known from time zero
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_ready = 1'b0;
    chars     = new();
  end

  // ---------------------------------------------------------------------------
  // idling helpers
  // ---------------------------------------------------------------------------
  function automatic int draw_wait(int style);
    case (style)
      IDLE_NONE: begin
        return 0;
      end
      IDLE_FULL: begin
        return $urandom_range(0, 9);
      end
      default: begin
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: note accepted bytes, check accepted results, count cycles
  // both handshakes sampled at the edge, before any driver update lands
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_cnt++;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        void'(chars.take_byte(in_word));
        fed_bytes++;
      end
      if (out_valid && out_ready) chars.check_char(out_word);
    end
  end

  // guard against a hung handshake
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: stall before each word, style changes every few dozen words
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    int taken;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 40 == 0) out_idle = $urandom_range(0, 2);
      stall = draw_wait(out_idle);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // one word on the input channel; caller sits at a rising edge.
  // with no gap valid just stays high for the next word
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_word_t w;
    int       gap;
    gap = draw_wait(in_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.data_byte      = b;
    w.last_of_string = fin;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [7:0] cont_byte();
    // mostly proper 10xxxxxx, now and then anything since they go unchecked
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // one random string: mostly well-formed sequences, some noise,
  // some strings cut short
  task automatic send_string();
    logic [7:0] bytes_q[$];
    int         n_seq;
    int         kind;
    int         cut;
    n_seq = $urandom_range(1, 6);
    repeat (n_seq) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          bytes_q.push_back(8'($urandom_range(0, 8'h7F)));
        end
        3: begin
          bytes_q.push_back(8'($urandom_range(8'hC0, 8'hDF)));
          bytes_q.push_back(cont_byte());
        end
        4: begin
          bytes_q.push_back(8'($urandom_range(8'hE0, 8'hEF)));
          bytes_q.push_back(cont_byte());
          bytes_q.push_back(cont_byte());
        end
        5: begin
          // 0xED as a plain three-byte lead
          bytes_q.push_back(SURR_LEAD);
          bytes_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
          bytes_q.push_back(cont_byte());
        end
        6, 7: begin
          // surrogate pair; fourth byte is sometimes random as it is never looked at
          bytes_q.push_back(SURR_LEAD);
          bytes_q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
          bytes_q.push_back(cont_byte());
          bytes_q.push_back(($urandom_range(0, 3) == 0) ?
                            8'($urandom_range(0, 255)) : SURR_LEAD);
          bytes_q.push_back(8'($urandom_range(8'hB0, 8'hBF)));
          bytes_q.push_back(cont_byte());
        end
        8: begin
          // bad lead: stray continuation or four-byte-and-up lead
          bytes_q.push_back(($urandom_range(0, 1) == 0) ?
                            8'($urandom_range(8'h80, 8'hBF)) :
                            8'($urandom_range(8'hF0, 8'hFF)));
        end
        default: begin
          bytes_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    // stray byte dropped somewhere in the middle
    if ($urandom_range(0, 9) == 0)
      bytes_q.insert($urandom_range(0, bytes_q.size()), 8'($urandom_range(0, 255)));
    // string ended mid-sequence
    if ($urandom_range(0, 7) == 0 && bytes_q.size() > 1) begin
      cut = $urandom_range(1, bytes_q.size() - 1);
      repeat (cut) void'(bytes_q.pop_back());
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int strings_sent;
    strings_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: ascii extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // two-byte extremes
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // three-byte, then 0xED taken as an ordinary lead
    send_byte(8'hE0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(SURR_LEAD, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'hBF, 1'b1);
    // full surrogate pair
    send_byte(SURR_LEAD, 1'b0);
    send_byte(8'hAF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(SURR_LEAD, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // continuation as lead, rest of string dropped
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hFF, 1'b1);
    // unsupported lead on the last byte
    send_byte(8'hF0, 1'b1);
    // strings cut short, one inside a pair
    send_byte(8'hE1, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(SURR_LEAD, 1'b0);
    send_byte(8'hA5, 1'b1);

    // random strings until enough bytes have been sent
    while (fed_bytes < TARGET_BYTES) begin
      if (strings_sent % 25 == 0) in_idle = $urandom_range(0, 2);
      send_string();
      strings_sent++;
    end
    in_valid <= 1'b0;

    // let every owed word come out, then a little longer for strays
    while (chars.due_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (chars.mismatches == 0 && chars.due_chars.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
